FILE: hdl/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared constants, types and the capacity table for the packed BCD converter.
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int VAL_W          = 64;   // binary input width
  localparam int NB_W           = 4;    // byte count register width
  localparam int FIELD_BYTES    = 10;   // widest output field
  localparam int FIELD_BITS     = FIELD_BYTES * 8;
  localparam int MAX_DIGITS_DEF = 20;
  localparam int BITS_PER_CYC   = 8;    // double-dabble steps per clock
  localparam int CONV_CYCLES    = VAL_W / BITS_PER_CYC;
  localparam int CONV_CNT_W     = $clog2(CONV_CYCLES);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [NB_W-1:0] NB_RESET = NB_W'(FIELD_BYTES);

  // One converted item handed from the front to the back
  typedef struct packed {
    logic [FIELD_BITS-1:0] bcd;     // digit 0 in the low nibble
    logic [NB_W-1:0]       nbytes;  // 1..10 when err is clear
    logic                  err;     // does not fit, or empty field
  } job_t;

  // 100 to the power of n, for field sizes that can overflow
  function automatic logic [VAL_W-1:0] cap_of(input logic [NB_W-1:0] n);
    logic [VAL_W-1:0] c;
    c = '0;
    case (n)
      4'd1:    c = 64'd100;
      4'd2:    c = 64'd10000;
      4'd3:    c = 64'd1000000;
      4'd4:    c = 64'd100000000;
      4'd5:    c = 64'd10000000000;
      4'd6:    c = 64'd1000000000000;
      4'd7:    c = 64'd100000000000000;
      4'd8:    c = 64'd10000000000000000;
      4'd9:    c = 64'd1000000000000000000;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/bpb_front.sv
// ----------------------------------------------------------------------------
// bpb_front
// Accepts a value, checks it against the field size and converts it to BCD
// with an iterative double-dabble, eight bits per clock.
// ----------------------------------------------------------------------------
module bpb_front import bpb_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [NB_W-1:0]  bcd_bytes,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_value,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  localparam int BW = 4 * MAX_DIGITS;

  logic                  busy;
  logic                  done;
  logic [CONV_CNT_W-1:0] cnt;
  logic [VAL_W-1:0]      bin;
  logic [BW-1:0]         bcd;
  logic [NB_W-1:0]       nb;
  logic                  err;

  logic [VAL_W-1:0]      bin_next;
  logic [BW-1:0]         bcd_next;
  logic [NB_W-1:0]       nsat;
  logic                  in_err;
  logic                  push;
  logic                  accept;

  // Field size saturates at ten bytes; ten always hold a 64-bit value
  always_comb begin
    nsat   = (bcd_bytes > NB_W'(FIELD_BYTES)) ? NB_W'(FIELD_BYTES) : bcd_bytes;
    in_err = (nsat == '0) ||
             ((nsat < NB_W'(FIELD_BYTES)) && (in_value >= cap_of(nsat)));
  end

  // Eight double-dabble steps; digits above the top one fall off
  always_comb begin
    bin_next = bin;
    bcd_next = bcd;
    for (int s = 0; s < BITS_PER_CYC; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_next[d*4 +: 4] >= 4'd5) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BW-2:0], bin_next[VAL_W-1]};
      bin_next = {bin_next[VAL_W-2:0], 1'b0};
    end
  end

  assign push      = done && job_ready;
  assign in_ready  = !busy || push;
  assign accept    = in_valid && in_ready;
  assign job_valid = done;

  always_comb begin
    job.bcd    = FIELD_BITS'(bcd);
    job.nbytes = nb;
    job.err    = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
      end else if (push) begin
        busy <= 1'b0;
        done <= 1'b0;
      end else if (busy && !done) begin
        cnt <= cnt + 1'b1;
        if (cnt == CONV_CNT_W'(CONV_CYCLES - 1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= in_value;
      bcd <= '0;
      nb  <= nsat;
      err <= in_err;
    end else if (busy && !done) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

endmodule

FILE: hdl/bpb_queue.sv
// ----------------------------------------------------------------------------
// bpb_queue
// Two-entry queue of converted items between the converter and the serializer.
// ----------------------------------------------------------------------------
module bpb_queue import bpb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_job;
    end
  end

endmodule

FILE: hdl/bpb_back.sv
// ----------------------------------------------------------------------------
// bpb_back
// Serializes a converted item into packed BCD bytes, most significant first,
// behind a registered output stage; an error item gives one zero byte.
// ----------------------------------------------------------------------------
module bpb_back import bpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_ok,
  output logic       out_last
);

  logic                  active;
  logic [FIELD_BITS-1:0] bcd;
  logic [NB_W-1:0]       k;      // byte index, counts down to zero
  logic                  err;

  logic                  adv;
  logic                  last_now;
  logic [7:0]            cur_byte;

  assign adv       = !out_valid || out_ready;
  assign last_now  = err || (k == '0);
  assign job_ready = !active || (adv && last_now);
  assign cur_byte  = bcd[{k, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        active <= 1'b1;
      end else if (adv && active && last_now) begin
        active <= 1'b0;
      end
      if (adv) begin
        out_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      bcd <= job.bcd;
      err <= job.err;
      k   <= job.nbytes - 1'b1;
    end else if (adv && active) begin
      k <= k - 1'b1;
    end
    if (adv && active) begin
      out_byte <= err ? 8'h00 : cur_byte;
      out_ok   <= !err;
      out_last <= last_now;
    end
  end

endmodule

FILE: hdl/binary_to_packed_bcd.sv
// The front converts a value, the two-entry queue holds it and the back registers
// each output byte; the front takes a new value as it hands the last one on. An
// item gives N bytes, N the byte count (1 error beat for a value that does not
// fit); the 8-bit output channel and the double-dabble loop bound the item rate.
// Reset: rst, synchronous; clears all control state and sets bcd_bytes to 10.
// ----------------------------------------------------------------------------
// binary_to_packed_bcd
// Converts a 64-bit unsigned value to a right-aligned packed BCD field.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd import bpb_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [NB_W-1:0]  cfg_data,   // bcd_bytes
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [VAL_W-1:0] s_tdata,    // [63:0] value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,    // [7:0] bcd_byte
  output logic             m_tuser,    // [0] ok
  output logic             m_tlast
);

  logic [NB_W-1:0] bcd_bytes;
  logic            f_valid;
  logic            f_ready;
  job_t            f_job;
  logic            b_valid;
  logic            b_ready;
  job_t            b_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcd_bytes <= NB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bcd_bytes <= cfg_data;
    end
  end

  bpb_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bcd_bytes (bcd_bytes),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  bpb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_job   (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_job   (b_job)
  );

  bpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_ok    (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
